// ===== hdl/pps_pkg.sv =====
// pps_pkg: shared types, status codes and defaults for the preemptive
// priority scheduler. No dependencies; used by pps_ctrl, pps_dpath and the top level.
package pps_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam logic [15:0] QUANTUM_RESET = 16'd1;
    localparam logic [31:0] TIME_MAX      = 32'hFFFF_FFFF;

    localparam logic CMD_ADD      = 1'b0;
    localparam logic CMD_DISPATCH = 1'b1;

    typedef enum logic [1:0] {
        ST_ADDED    = 2'd0,
        ST_FULL     = 2'd1,
        ST_DISPATCH = 2'd2,
        ST_IDLE     = 2'd3
    } status_t;

    // One job record as held in the table memory.
    typedef struct packed {
        logic [7:0]  job;
        logic [31:0] arrival;
        logic [7:0]  prio;
        logic [15:0] burst;
        logic [15:0] remaining;
        logic        started;
        logic [31:0] first_start;
    } entry_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic latch_in;   // capture the transaction's fields
        logic rd_scan;    // read entry at scan address
        logic rd_pick;    // read the chosen entry
        logic cmp_en;     // compare registered read data against best
        logic add_wr;     // store a new job at scan address
        logic idle_en;    // idle slot: advance counter, load result
        logic calc_en;    // slot length, new remaining, new time
        logic commit_en;  // write back entry, update counter, retire
        logic final_en;   // waiting time, load dispatch result
        logic out_add;    // load "added" result
        logic out_full;   // load "table full" result
    } ctl_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic free;       // entry at scan address is not valid
        logic found;      // scan found an eligible job
    } ctl_stat_t;

endpackage

// ===== hdl/preemptive_priority_scheduler.sv =====
// Preemptive priority scheduler top level: controller plus datapath.
// Depends on pps_pkg, pps_ctrl and pps_dpath.
//
//  channel   handshake                 payload
//  --------  ------------------------  ------------------------------------------
//  request   start & !busy             cmd, job_id, arrival_time, job_priority,
//                                      burst_time
//  result    done (one cycle)          status, slot_job, slot_start, finished,
//                                      first_start, finish_time, turnaround,
//                                      waiting, held_count
//  config    quantum_we                quantum_wdata (time_quantum)
//
// An add scans for the lowest free entry, walking the valid bits one entry per cycle, and
// ends when it writes one or finds the table full. A dispatch reads every entry and picks;
// if a job is found it goes on through load, commit and final steps. One read port,
// one entry compared per cycle. done rises at the edge where busy falls, so the next
// transaction may be accepted while the result is shown. Reset clears the valid bits and
// the time counter and sets the quantum to 1. The result side cannot stall.
module preemptive_priority_scheduler #(
    parameter int TABLE_DEPTH = pps_pkg::DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               cmd,
    input  logic [7:0]                         job_id,
    input  logic [31:0]                        arrival_time,
    input  logic [7:0]                         job_priority,
    input  logic [15:0]                        burst_time,
    output logic                               done,
    output logic [1:0]                         status,
    output logic [7:0]                         slot_job,
    output logic [31:0]                        slot_start,
    output logic                               finished,
    output logic [31:0]                        first_start,
    output logic [31:0]                        finish_time,
    output logic [31:0]                        turnaround,
    output logic [31:0]                        waiting,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]   held_count,
    input  logic                               quantum_we,
    input  logic [15:0]                        quantum_wdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    pps_pkg::ctl_cmd_t  ctl;
    pps_pkg::ctl_stat_t stat;
    logic [IDX_W-1:0]   addr;

    pps_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl),
        .addr  (addr),
        .stat  (stat)
    );

    pps_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .addr          (addr),
        .stat          (stat),
        .quantum_we    (quantum_we),
        .quantum_wdata (quantum_wdata),
        .job_id        (job_id),
        .arrival_time  (arrival_time),
        .job_priority  (job_priority),
        .burst_time    (burst_time),
        .status        (status),
        .slot_job      (slot_job),
        .slot_start    (slot_start),
        .finished      (finished),
        .first_start   (first_start),
        .finish_time   (finish_time),
        .turnaround    (turnaround),
        .waiting       (waiting),
        .held_count    (held_count)
    );

endmodule

// ===== hdl/pps_dpath.sv =====
// pps_dpath: job table memory, valid bits, time counter, quantum register,
// selection compare and slot arithmetic. Depends on pps_pkg; driven by pps_ctrl.
module pps_dpath #(
    parameter int TABLE_DEPTH = pps_pkg::DEPTH_DEFAULT,
    parameter int IDX_W       = $clog2(TABLE_DEPTH),
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pps_pkg::ctl_cmd_t   ctl,
    input  logic [IDX_W-1:0]    addr,
    output pps_pkg::ctl_stat_t  stat,
    input  logic                quantum_we,
    input  logic [15:0]         quantum_wdata,
    input  logic [7:0]          job_id,
    input  logic [31:0]         arrival_time,
    input  logic [7:0]          job_priority,
    input  logic [15:0]         burst_time,
    output logic [1:0]          status,
    output logic [7:0]          slot_job,
    output logic [31:0]         slot_start,
    output logic                finished,
    output logic [31:0]         first_start,
    output logic [31:0]         finish_time,
    output logic [31:0]         turnaround,
    output logic [31:0]         waiting,
    output logic [CNT_W-1:0]    held_count
);

    pps_pkg::entry_t mem [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [31:0]            time_reg;
    logic [15:0]            quantum_reg;

    // captured transaction fields
    logic [7:0]  in_job_reg;
    logic [31:0] in_arrival_reg;
    logic [7:0]  in_prio_reg;
    logic [15:0] in_burst_reg;

    // read port
    pps_pkg::entry_t  rd_data_reg;
    logic             rd_valid_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    // best candidate so far
    logic             best_found_reg;
    logic [7:0]       best_prio_reg;
    logic [7:0]       best_job_reg;
    logic [IDX_W-1:0] best_idx_reg;

    // slot arithmetic
    logic [15:0] rem_new_reg;
    logic [31:0] time_new_reg;
    logic [31:0] slot_start_reg;
    logic [31:0] fs_new_reg;
    logic [31:0] tat_reg;
    logic        fin_reg;

    // result registers
    logic [1:0]       status_reg;
    logic [7:0]       slot_job_reg;
    logic [31:0]      slot_start_out_reg;
    logic             finished_reg;
    logic [31:0]      first_start_reg;
    logic [31:0]      finish_time_reg;
    logic [31:0]      turnaround_reg;
    logic [31:0]      waiting_reg;
    logic [CNT_W-1:0] held_reg;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    pps_pkg::entry_t  mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;

    logic             eligible;
    logic             better;
    logic [15:0]      run;
    logic [32:0]      run_sum;
    logic [32:0]      idle_sum;
    logic [31:0]      wait_diff;

    assign stat.free  = ~valid_reg[addr];
    assign stat.found = best_found_reg;

    assign eligible = rd_valid_reg && (rd_data_reg.arrival <= time_reg);
    assign better   = !best_found_reg
                   || (rd_data_reg.prio < best_prio_reg)
                   || ((rd_data_reg.prio == best_prio_reg) && (rd_data_reg.job < best_job_reg));

    assign run      = (rd_data_reg.remaining < quantum_reg) ? rd_data_reg.remaining : quantum_reg;
    assign run_sum  = {1'b0, time_reg} + {17'd0, run};
    assign idle_sum = {1'b0, time_reg} + {17'd0, quantum_reg};
    assign wait_diff = tat_reg - {16'd0, rd_data_reg.burst};

    always_comb
    begin
        mem_we    = ctl.add_wr | ctl.commit_en;
        mem_waddr = ctl.add_wr ? addr : best_idx_reg;
        if (ctl.add_wr)
        begin
            mem_wdata.job         = in_job_reg;
            mem_wdata.arrival     = in_arrival_reg;
            mem_wdata.prio        = in_prio_reg;
            mem_wdata.burst       = in_burst_reg;
            mem_wdata.remaining   = in_burst_reg;
            mem_wdata.started     = 1'b0;
            mem_wdata.first_start = 32'd0;
        end
        else
        begin
            mem_wdata             = rd_data_reg;
            mem_wdata.remaining   = rem_new_reg;
            mem_wdata.started     = 1'b1;
            mem_wdata.first_start = fs_new_reg;
        end
        mem_re    = ctl.rd_scan | ctl.rd_pick;
        mem_raddr = ctl.rd_pick ? best_idx_reg : addr;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.latch_in)
        begin
            in_job_reg     <= job_id;
            in_arrival_reg <= arrival_time;
            in_prio_reg    <= job_priority;
            in_burst_reg   <= burst_time;
        end
        if (mem_re)
        begin
            rd_valid_reg <= valid_reg[mem_raddr];
            rd_idx_reg   <= mem_raddr;
        end
        if (ctl.cmp_en && eligible && better)
        begin
            best_prio_reg <= rd_data_reg.prio;
            best_job_reg  <= rd_data_reg.job;
            best_idx_reg  <= rd_idx_reg;
        end
        if (ctl.calc_en)
        begin
            rem_new_reg    <= rd_data_reg.remaining - run;
            time_new_reg   <= run_sum[32] ? pps_pkg::TIME_MAX : run_sum[31:0];
            slot_start_reg <= time_reg;
            fs_new_reg     <= rd_data_reg.started ? rd_data_reg.first_start : time_reg;
        end
        if (ctl.commit_en)
        begin
            tat_reg <= time_new_reg - rd_data_reg.arrival;
            fin_reg <= (rem_new_reg == 16'd0);
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (ctl.out_add || ctl.out_full || ctl.idle_en || ctl.final_en)
        begin
            status_reg         <= ctl.out_add  ? pps_pkg::ST_ADDED :
                                  ctl.out_full ? pps_pkg::ST_FULL  :
                                  ctl.idle_en  ? pps_pkg::ST_IDLE  : pps_pkg::ST_DISPATCH;
            slot_job_reg       <= ctl.final_en ? rd_data_reg.job : 8'd0;
            slot_start_out_reg <= ctl.idle_en  ? time_reg :
                                  ctl.final_en ? slot_start_reg : 32'd0;
            finished_reg       <= ctl.final_en & fin_reg;
            first_start_reg    <= (ctl.final_en && fin_reg) ? fs_new_reg : 32'd0;
            finish_time_reg    <= (ctl.final_en && fin_reg) ? time_new_reg : 32'd0;
            turnaround_reg     <= (ctl.final_en && fin_reg) ? tat_reg : 32'd0;
            // waiting clamps at zero, reachable only after counter saturation
            waiting_reg        <= (ctl.final_en && fin_reg && (tat_reg >= {16'd0, rd_data_reg.burst}))
                                  ? wait_diff : 32'd0;
            held_reg           <= count_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            count_reg      <= '0;
            time_reg       <= '0;
            quantum_reg    <= pps_pkg::QUANTUM_RESET;
            best_found_reg <= 1'b0;
        end
        else
        begin
            if (quantum_we)
            begin
                quantum_reg <= quantum_wdata;
            end
            if (ctl.latch_in)
            begin
                best_found_reg <= 1'b0;
            end
            else if (ctl.cmp_en && eligible)
            begin
                best_found_reg <= 1'b1;
            end
            if (ctl.add_wr)
            begin
                valid_reg[addr] <= 1'b1;
                count_reg       <= count_reg + CNT_W'(1);
            end
            if (ctl.idle_en)
            begin
                time_reg <= idle_sum[32] ? pps_pkg::TIME_MAX : idle_sum[31:0];
            end
            if (ctl.commit_en)
            begin
                time_reg <= time_new_reg;
                if (rem_new_reg == 16'd0)
                begin
                    valid_reg[best_idx_reg] <= 1'b0;
                    count_reg               <= count_reg - CNT_W'(1);
                end
            end
        end
    end

    assign status      = status_reg;
    assign slot_job    = slot_job_reg;
    assign slot_start  = slot_start_out_reg;
    assign finished    = finished_reg;
    assign first_start = first_start_reg;
    assign finish_time = finish_time_reg;
    assign turnaround  = turnaround_reg;
    assign waiting     = waiting_reg;
    assign held_count  = held_reg;

endmodule

// ===== hdl/pps_ctrl.sv =====
// pps_ctrl: sequencing state machine for add and dispatch transactions,
// scan counter, busy and result strobe. Depends on pps_pkg; drives pps_dpath.
module pps_ctrl #(
    parameter int TABLE_DEPTH = pps_pkg::DEPTH_DEFAULT,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                cmd,
    output logic                busy,
    output logic                done,
    output pps_pkg::ctl_cmd_t   ctl,
    output logic [IDX_W-1:0]    addr,
    input  pps_pkg::ctl_stat_t  stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_ADD_DONE,
        S_DSP_SCAN,
        S_DSP_DRAIN,
        S_DSP_PICK,
        S_DSP_LOAD,
        S_DSP_COMMIT,
        S_DSP_FINAL
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    state_t           state_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             busy_reg;
    logic             done_reg;

    assign addr = idx_reg;
    assign busy = busy_reg;
    assign done = done_reg;

    always_comb
    begin
        ctl = '0;
        case (state_reg)
            S_IDLE:
            begin
                ctl.latch_in = start;
            end
            S_ADD_SCAN:
            begin
                ctl.add_wr   = stat.free;
                ctl.out_full = !stat.free && (idx_reg == LAST_IDX);
            end
            S_ADD_DONE:
            begin
                ctl.out_add = 1'b1;
            end
            S_DSP_SCAN:
            begin
                ctl.rd_scan = 1'b1;
                ctl.cmp_en  = (idx_reg != '0);
            end
            S_DSP_DRAIN:
            begin
                ctl.cmp_en = 1'b1;
            end
            S_DSP_PICK:
            begin
                ctl.rd_pick = stat.found;
                ctl.idle_en = !stat.found;
            end
            S_DSP_LOAD:
            begin
                ctl.calc_en = 1'b1;
            end
            S_DSP_COMMIT:
            begin
                ctl.commit_en = 1'b1;
            end
            S_DSP_FINAL:
            begin
                ctl.final_en = 1'b1;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        idx_reg   <= '0;
                        busy_reg  <= 1'b1;
                        state_reg <= (cmd == pps_pkg::CMD_ADD) ? S_ADD_SCAN : S_DSP_SCAN;
                    end
                end
                S_ADD_SCAN:
                begin
                    if (stat.free)
                    begin
                        state_reg <= S_ADD_DONE;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        done_reg  <= 1'b1;
                        busy_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                S_ADD_DONE:
                begin
                    done_reg  <= 1'b1;
                    busy_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
                S_DSP_SCAN:
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= S_DSP_DRAIN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                S_DSP_DRAIN:
                begin
                    state_reg <= S_DSP_PICK;
                end
                S_DSP_PICK:
                begin
                    if (stat.found)
                    begin
                        state_reg <= S_DSP_LOAD;
                    end
                    else
                    begin
                        done_reg  <= 1'b1;
                        busy_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                S_DSP_LOAD:
                begin
                    state_reg <= S_DSP_COMMIT;
                end
                S_DSP_COMMIT:
                begin
                    state_reg <= S_DSP_FINAL;
                end
                S_DSP_FINAL:
                begin
                    done_reg  <= 1'b1;
                    busy_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    busy_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sim/pps_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the preemptive priority scheduler: tracks the job table and time counter,
// predicts each slot result and compares it with the DUT's done output.
// Depends on pps_pkg.
module pps_checker #(
    parameter int TABLE_DEPTH = pps_pkg::DEPTH_DEFAULT,
    parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  logic          cmd,
    input  logic [7:0]    job_id,
    input  logic [31:0]   arrival_time,
    input  logic [7:0]    job_priority,
    input  logic [15:0]   burst_time,
    input  logic          done,
    input  logic [1:0]    status,
    input  logic [7:0]    slot_job,
    input  logic [31:0]   slot_start,
    input  logic          finished,
    input  logic [31:0]   first_start,
    input  logic [31:0]   finish_time,
    input  logic [31:0]   turnaround,
    input  logic [31:0]   waiting,
    input  logic [CW-1:0] held_count,
    input  logic          quantum_we,
    input  logic [15:0]   quantum_wdata,
    output logic [31:0]   mismatches,
    output logic [15:0]   backlog,
    output logic [31:0]   sched_time
);

    typedef struct packed {
        pps_pkg::status_t status;
        logic [7:0]       job;
        logic [31:0]      slot_start;
        logic             finished;
        logic [31:0]      first_start;
        logic [31:0]      finish_time;
        logic [31:0]      turnaround;
        logic [31:0]      waiting;
        logic [CW-1:0]    held;
    } slot_result_t;

    pps_pkg::entry_t job_table [TABLE_DEPTH];
    logic            job_live  [TABLE_DEPTH];
    logic [31:0]     sched_clock;
    logic [15:0]     slot_quantum;
    slot_result_t    slots_due [$];
    int              fail_count = 0;

    assign mismatches = fail_count;

    function automatic logic [31:0] clock_advance(input logic [31:0] base,
                                                  input logic [15:0] step);
        logic [32:0] sum;
        sum = {1'b0, base} + {17'd0, step};
        return sum[32] ? pps_pkg::TIME_MAX : sum[31:0];
    endfunction

    function automatic slot_result_t predict_slot(input logic op, input logic [7:0] a_job,
                                                  input logic [31:0] a_arrival,
                                                  input logic [7:0] a_prio,
                                                  input logic [15:0] a_burst);
        slot_result_t r;
        int           pick;
        int           n;
        logic [15:0]  run;
        logic [31:0]  tat;
        r    = '0;
        pick = -1;
        n    = 0;
        if (op == pps_pkg::CMD_ADD) begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (!job_live[i] && pick < 0)
                    pick = i;
            if (pick < 0) begin
                r.status = pps_pkg::ST_FULL;
            end
            else begin
                job_live[pick]              = 1'b1;
                job_table[pick].job         = a_job;
                job_table[pick].arrival     = a_arrival;
                job_table[pick].prio        = a_prio;
                job_table[pick].burst       = a_burst;
                job_table[pick].remaining   = a_burst;
                job_table[pick].started     = 1'b0;
                job_table[pick].first_start = '0;
                r.status                    = pps_pkg::ST_ADDED;
            end
        end
        else begin
            // eligible = arrived by now; lowest priority number, then lowest id, then lowest entry
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (job_live[i] && job_table[i].arrival <= sched_clock) begin
                    if (pick < 0 || job_table[i].prio < job_table[pick].prio ||
                        (job_table[i].prio == job_table[pick].prio &&
                         job_table[i].job < job_table[pick].job))
                        pick = i;
                end
            end
            r.slot_start = sched_clock;
            if (pick < 0) begin
                r.status    = pps_pkg::ST_IDLE;
                sched_clock = clock_advance(sched_clock, slot_quantum);
            end
            else begin
                run = (job_table[pick].remaining < slot_quantum) ?
                      job_table[pick].remaining : slot_quantum;
                r.status = pps_pkg::ST_DISPATCH;
                r.job    = job_table[pick].job;
                if (!job_table[pick].started) begin
                    job_table[pick].started     = 1'b1;
                    job_table[pick].first_start = sched_clock;
                end
                job_table[pick].remaining = job_table[pick].remaining - run;
                sched_clock = clock_advance(sched_clock, run);
                if (job_table[pick].remaining == 16'd0) begin
                    tat           = sched_clock - job_table[pick].arrival;
                    r.finished    = 1'b1;
                    r.first_start = job_table[pick].first_start;
                    r.finish_time = sched_clock;
                    r.turnaround  = tat;
                    // only a saturated counter can make this negative
                    r.waiting     = (tat >= {16'd0, job_table[pick].burst}) ?
                                    tat - {16'd0, job_table[pick].burst} : 32'd0;
                    job_live[pick] = 1'b0;
                end
            end
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (job_live[i])
                n++;
        r.held = CW'(n);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            if (fail_count < 10)
                $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        slot_result_t want;
        if (!rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                job_live[i]  = 1'b0;
                job_table[i] = '0;
            end
            sched_clock  = '0;
            slot_quantum = pps_pkg::QUANTUM_RESET;
            slots_due.delete();
            backlog    <= '0;
            sched_time <= '0;
        end
        else begin
            // retire the finished transaction before predicting a newly accepted one
            if (done) begin
                if (slots_due.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: result with nothing expected (status %0d)",
                                 $time, status);
                    fail_count++;
                end
                else begin
                    want = slots_due.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("slot_job", 32'(want.job), 32'(slot_job));
                    check_field("slot_start", want.slot_start, slot_start);
                    check_field("finished", 32'(want.finished), 32'(finished));
                    check_field("first_start", want.first_start, first_start);
                    check_field("finish_time", want.finish_time, finish_time);
                    check_field("turnaround", want.turnaround, turnaround);
                    check_field("waiting", want.waiting, waiting);
                    check_field("held_count", 32'(want.held), 32'(held_count));
                end
            end
            if (start && !busy)
                slots_due.insert(slots_due.size(),
                                 predict_slot(cmd, job_id, arrival_time, job_priority,
                                              burst_time));
            if (quantum_we)
                slot_quantum = quantum_wdata;
            backlog    <= 16'(slots_due.size());
            sched_time <= sched_clock;
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for preemptive_priority_scheduler: clock, reset, directed and random
// add/dispatch transactions, quantum writes and the verdict. Depends on pps_pkg and pps_checker.
module tb;

    localparam int TABLE_DEPTH = pps_pkg::DEPTH_DEFAULT;
    localparam int CW          = $clog2(TABLE_DEPTH + 1);
    localparam int SETTLE      = TABLE_DEPTH + 8;
    localparam int CYCLE_LIMIT = 6_000_000;

    logic          clk           = 1'b0;
    logic          rst_n         = 1'b0;
    logic          start         = 1'b0;
    logic          cmd           = pps_pkg::CMD_ADD;
    logic [7:0]    job_id        = '0;
    logic [31:0]   arrival_time  = '0;
    logic [7:0]    job_priority  = '0;
    logic [15:0]   burst_time    = '0;
    logic          quantum_we    = 1'b0;
    logic [15:0]   quantum_wdata = '0;
    logic          busy;
    logic          done;
    logic [1:0]    status;
    logic [7:0]    slot_job;
    logic [31:0]   slot_start;
    logic          finished;
    logic [31:0]   first_start;
    logic [31:0]   finish_time;
    logic [31:0]   turnaround;
    logic [31:0]   waiting;
    logic [CW-1:0] held_count;
    logic [31:0]   mismatches;
    logic [15:0]   backlog;
    logic [31:0]   model_time;

    int            cycle_count = 0;
    bit            gaps_on     = 1'b1;
    logic [15:0]   cur_quantum = pps_pkg::QUANTUM_RESET;
    int            phase_quantum  [8] = '{1, 4, 65535, 16, 3, 1000, 2, 65535};
    int            phase_dispatch [8] = '{40, 55, 50, 65, 30, 60, 70, 80};

    preemptive_priority_scheduler #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .job_id(job_id),
        .arrival_time(arrival_time), .job_priority(job_priority), .burst_time(burst_time),
        .done(done), .status(status), .slot_job(slot_job), .slot_start(slot_start),
        .finished(finished), .first_start(first_start), .finish_time(finish_time),
        .turnaround(turnaround), .waiting(waiting), .held_count(held_count),
        .quantum_we(quantum_we), .quantum_wdata(quantum_wdata)
    );

    pps_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .job_id(job_id),
        .arrival_time(arrival_time), .job_priority(job_priority), .burst_time(burst_time),
        .done(done), .status(status), .slot_job(slot_job), .slot_start(slot_start),
        .finished(finished), .first_start(first_start), .finish_time(finish_time),
        .turnaround(turnaround), .waiting(waiting), .held_count(held_count),
        .quantum_we(quantum_we), .quantum_wdata(quantum_wdata),
        .mismatches(mismatches), .backlog(backlog), .sched_time(model_time)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, backlog);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Present one transaction and hold it until accepted; start stays high afterwards
    // unless a gap follows.
    task automatic send(input logic c, input logic [7:0] id, input logic [31:0] arr,
                        input logic [7:0] pr, input logic [15:0] bt);
        int gap;
        start        <= 1'b1;
        cmd          <= c;
        job_id       <= id;
        arrival_time <= arr;
        job_priority <= pr;
        burst_time   <= bt;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off until every issued transaction has produced its result.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
    endtask

    task automatic set_quantum(input logic [15:0] q);
        drain();
        quantum_we    <= 1'b1;
        quantum_wdata <= q;
        cur_quantum    = q;
        @(posedge clk);
        quantum_we    <= 1'b0;
    endtask

    task automatic random_item(input int pct_dispatch, input bit wide_burst);
        logic        c;
        logic [7:0]  id;
        logic [7:0]  pr;
        logic [31:0] arr;
        logic [31:0] now;
        logic [31:0] d;
        logic [15:0] bt;
        int          span;
        now  = model_time;
        span = (cur_quantum == 0) ? 1 : cur_quantum;
        c    = ($urandom_range(0, 99) < pct_dispatch) ? pps_pkg::CMD_DISPATCH : pps_pkg::CMD_ADD;
        // narrow id and priority ranges to make ties common
        id   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
        pr   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3));
        if ($urandom_range(0, 99) == 0) begin
            arr = $urandom();
        end
        else if ($urandom_range(0, 1) == 0) begin
            d   = $urandom_range(0, 1000);
            arr = (now > d) ? now - d : 32'd0;
        end
        else begin
            d   = $urandom_range(0, 4 * span);
            arr = (now > pps_pkg::TIME_MAX - d) ? pps_pkg::TIME_MAX : now + d;
        end
        if (wide_burst)
            bt = 16'($urandom_range(0, 65535));
        else if ($urandom_range(0, 19) == 0)
            bt = 16'd0;
        else
            bt = 16'($urandom_range(0, (3 * span > 65535) ? 65535 : 3 * span));
        send(c, id, arr, pr, bt);
        if ($urandom_range(0, 49) == 0)
            drain();
    endtask

    initial
    begin
        int k;
        int p;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle slot, field extremes, zero burst, duplicate ids, table full
        send(pps_pkg::CMD_DISPATCH, 8'h00, 32'h0, 8'h00, 16'h0000);
        send(pps_pkg::CMD_ADD, 8'hFF, 32'h0, 8'hFF, 16'h0000);
        send(pps_pkg::CMD_ADD, 8'h00, 32'hFFFF_FFFF, 8'h00, 16'hFFFF);
        send(pps_pkg::CMD_ADD, 8'h03, 32'h0, 8'h01, 16'h0002);
        send(pps_pkg::CMD_ADD, 8'h03, 32'h0, 8'h01, 16'h0001);
        send(pps_pkg::CMD_ADD, 8'h02, 32'h1, 8'h01, 16'h0001);
        // last of these finds the table full
        for (k = 0; k < 12; k++)
            send(pps_pkg::CMD_ADD, 8'(8'h10 + k), 32'(5 + k), 8'h80, 16'h0001);
        for (k = 0; k < 5; k++)
            send(pps_pkg::CMD_DISPATCH, 8'h00, 32'h0, 8'h00, 16'h0000);
        // zero-length slots: the chosen job makes no progress
        set_quantum(16'd0);
        for (k = 0; k < 2; k++)
            send(pps_pkg::CMD_DISPATCH, 8'h00, 32'h0, 8'h00, 16'h0000);

        for (p = 0; p < 8; p++) begin
            set_quantum(phase_quantum[p][15:0]);
            gaps_on = (p != 2);
            for (k = 0; k < 44; k++)
                random_item(phase_dispatch[p], phase_quantum[p] == 65535);
        end

        for (k = 0; k < 24; k++)
            send(pps_pkg::CMD_DISPATCH, 8'h00, 32'h0, 8'h00, 16'h0000);

        drain();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
